// ----- design/lphm_pkg.sv -----
// ----------------------------------------------------------------------------
// lphm_pkg
// Shared constants and types of the linear probing hash map: request and
// status codes, key width and the controller states.
// ----------------------------------------------------------------------------
package lphm_pkg;

  localparam int KEY_W    = 32;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;

  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_ABSENT = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_PROBE,
    ST_ERASE,
    ST_DONE
  } state_t;

endpackage

// ----- design/lphm_home.sv -----
// ----------------------------------------------------------------------------
// lphm_home
// Home slot unit: key modulo the table size. A power-of-two table registers the
// low key bits; any other size reduces four key bits a cycle.
// ----------------------------------------------------------------------------
module lphm_home #(
  parameter int TABLE_SLOTS = 1024,
  localparam int IDX_W = $clog2(TABLE_SLOTS)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [lphm_pkg::KEY_W-1:0] key,
  output logic                       done,
  output logic [IDX_W-1:0]           home
);
  import lphm_pkg::*;

  localparam bit IS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;

  generate
    if (IS_POW2) begin : g_pow2
      always_ff @(posedge clk) begin
        if (rst) begin
          done <= 1'b0;
        end else begin
          done <= start;
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          home <= key[IDX_W-1:0];
        end
      end
    end else begin : g_serial
      localparam int NIB_STEPS = KEY_W / 4;
      localparam int CNT_W     = $clog2(NIB_STEPS);
      localparam int T_W       = IDX_W + 4;
      localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NIB_STEPS - 1);

      logic             busy;
      logic [CNT_W-1:0] cnt;
      logic [KEY_W-1:0] shift;
      logic [IDX_W-1:0] rem;
      logic [T_W-1:0]   red;

      always_comb begin
        logic [T_W-1:0] sub;
        red = {rem, shift[KEY_W-1 -: 4]};
        for (int s = 3; s >= 0; s--) begin
          sub = T_W'(TABLE_SLOTS) << s;
          if (red >= sub) begin
            red = red - sub;
          end
        end
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          busy <= 1'b0;
          done <= 1'b0;
        end else begin
          done <= 1'b0;
          if (start) begin
            busy <= 1'b1;
          end else if (busy && cnt == CNT_LAST) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end

      always_ff @(posedge clk) begin
        if (start) begin
          rem   <= '0;
          shift <= key;
          cnt   <= '0;
        end else if (busy) begin
          rem   <= red[IDX_W-1:0];
          shift <= shift << 4;
          cnt   <= cnt + 1'b1;
        end
      end

      assign home = rem;
    end
  endgenerate

endmodule

// ----- design/lphm_mem.sv -----
// ----------------------------------------------------------------------------
// lphm_mem
// Slot memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lphm_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 64,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- design/linear_probe_hash_map_core.sv -----
// ----------------------------------------------------------------------------
// linear_probe_hash_map_core
// Open addressing hash table with linear probing and backward-shift removal.
// Steps: accept, home slot (a serial reduction for a non-power-of-two table),
//   probe slot by slot, walk the chain on removal, then register the result.
// One request is in work at a time; the next is accepted while the
//   previous result waits on the output.
// Reset: clears control state, then walks the slot memory to mark every
//   slot empty; no request is accepted during that pass.
// ----------------------------------------------------------------------------
module linear_probe_hash_map_core #(
  parameter int TABLE_SLOTS   = 1024,
  parameter int POOL_BITS     = 4,
  parameter int POSITION_BITS = 16,
  localparam int S_W = ((lphm_pkg::KEY_W + POOL_BITS + POSITION_BITS + 7) / 8) * 8,
  localparam int M_W = ((POOL_BITS + POSITION_BITS + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // order_key, pool_id, order_slot
  input  logic [S_W-1:0]                s_axis_tdata,
  // action
  input  logic [lphm_pkg::ACTION_W-1:0] s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // found_pool, found_slot
  output logic [M_W-1:0]                m_axis_tdata,
  // status
  output logic [lphm_pkg::STATUS_W-1:0] m_axis_tuser
);
  import lphm_pkg::*;

  localparam int IDX_W = $clog2(TABLE_SLOTS);
  localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TABLE_SLOTS - 1);
  localparam logic [CNT_W:0]   SLOTS_C  = (CNT_W + 1)'(TABLE_SLOTS);

  typedef struct packed {
    logic                     valid;
    logic [KEY_W-1:0]         key;
    logic [POOL_BITS-1:0]     pool;
    logic [POSITION_BITS-1:0] pos;
    logic [IDX_W-1:0]         home;
  } entry_t;

  localparam int ENT_W = $bits(entry_t);

  state_t state, state_next;

  logic [ACTION_W-1:0]      action, action_next;
  logic [KEY_W-1:0]         key, key_next;
  logic [POOL_BITS-1:0]     pool, pool_next;
  logic [POSITION_BITS-1:0] pos, pos_next;
  logic [IDX_W-1:0]         probe_idx, probe_idx_next;
  logic [IDX_W-1:0]         hole, hole_next;
  logic [IDX_W-1:0]         clr_idx, clr_idx_next;
  logic [CNT_W-1:0]         count, count_next;
  logic [STATUS_W-1:0]      res_status, res_status_next;
  logic [POOL_BITS-1:0]     res_pool, res_pool_next;
  logic [POSITION_BITS-1:0] res_pos, res_pos_next;
  logic                     out_valid, out_valid_next;
  logic [STATUS_W-1:0]      out_status, out_status_next;
  logic [POOL_BITS-1:0]     out_pool, out_pool_next;
  logic [POSITION_BITS-1:0] out_pos, out_pos_next;

  logic                     home_start;
  logic                     home_done;
  logic [IDX_W-1:0]         home;

  logic                     mem_we;
  logic [IDX_W-1:0]         mem_waddr;
  entry_t                   mem_wdata;
  logic [IDX_W-1:0]         rd_addr;
  logic [ENT_W-1:0]         mem_rdata;
  entry_t                   rd;

  logic [IDX_W-1:0]         idx_inc;
  logic                     full;
  logic                     stay;

  lphm_home #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) u_home (
    .clk  (clk),
    .rst  (rst),
    .start(home_start),
    .key  (key_next),
    .done (home_done),
    .home (home)
  );

  lphm_mem #(
    .DEPTH(TABLE_SLOTS),
    .WIDTH(ENT_W)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(rd_addr),
    .rdata(mem_rdata)
  );

  assign rd      = entry_t'(mem_rdata);
  assign idx_inc = (probe_idx == IDX_LAST) ? '0 : probe_idx + 1'b1;
  assign full    = {count, 1'b0} >= SLOTS_C;
  assign stay    = (hole <= probe_idx) ? ((hole < rd.home) && (rd.home <= probe_idx))
                                       : ((hole < rd.home) || (rd.home <= probe_idx));

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_status;
  assign m_axis_tdata  = M_W'({out_pos, out_pool});

  always_comb begin
    state_next      = state;
    action_next     = action;
    key_next        = key;
    pool_next       = pool;
    pos_next        = pos;
    probe_idx_next  = probe_idx;
    hole_next       = hole;
    clr_idx_next    = clr_idx;
    count_next      = count;
    res_status_next = res_status;
    res_pool_next   = res_pool;
    res_pos_next    = res_pos;
    out_valid_next  = out_valid && !m_axis_tready;
    out_status_next = out_status;
    out_pool_next   = out_pool;
    out_pos_next    = out_pos;
    home_start      = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = hole;
    mem_wdata       = '0;
    rd_addr         = probe_idx;

    unique case (state)
      ST_CLEAR: begin
        mem_we       = 1'b1;
        mem_waddr    = clr_idx;
        clr_idx_next = clr_idx + 1'b1;
        if (clr_idx == IDX_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          action_next     = s_axis_tuser;
          key_next        = s_axis_tdata[KEY_W-1:0];
          pool_next       = s_axis_tdata[KEY_W +: POOL_BITS];
          pos_next        = s_axis_tdata[KEY_W + POOL_BITS +: POSITION_BITS];
          res_status_next = STAT_ABSENT;
          res_pool_next   = '0;
          res_pos_next    = '0;
          if (s_axis_tuser == ACT_INSERT || s_axis_tuser == ACT_LOOKUP ||
              s_axis_tuser == ACT_REMOVE) begin
            home_start = 1'b1;
            state_next = ST_HASH;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_HASH: begin
        if (home_done) begin
          rd_addr        = home;
          probe_idx_next = home;
          state_next     = ST_PROBE;
        end
      end
      ST_PROBE: begin
        priority if (!rd.valid) begin
          state_next = ST_DONE;
          if (action == ACT_INSERT) begin
            if (full) begin
              res_status_next = STAT_FULL;
            end else begin
              mem_we          = 1'b1;
              mem_waddr       = probe_idx;
              mem_wdata       = '{valid: 1'b1, key: key, pool: pool, pos: pos, home: home};
              count_next      = count + 1'b1;
              res_status_next = STAT_OK;
            end
          end
        end else if (rd.key == key) begin
          res_status_next = STAT_OK;
          priority if (action == ACT_INSERT) begin
            mem_we     = 1'b1;
            mem_waddr  = probe_idx;
            mem_wdata  = '{valid: 1'b1, key: key, pool: pool, pos: pos, home: rd.home};
            state_next = ST_DONE;
          end else if (action == ACT_LOOKUP) begin
            res_pool_next = rd.pool;
            res_pos_next  = rd.pos;
            state_next    = ST_DONE;
          end else begin
            hole_next      = probe_idx;
            rd_addr        = idx_inc;
            probe_idx_next = idx_inc;
            state_next     = ST_ERASE;
          end
        end else begin
          rd_addr        = idx_inc;
          probe_idx_next = idx_inc;
        end
      end
      ST_ERASE: begin
        if (!rd.valid || probe_idx == hole) begin
          mem_we    = 1'b1;
          mem_waddr = hole;
          if (count != '0) begin
            count_next = count - 1'b1;
          end
          state_next = ST_DONE;
        end else begin
          rd_addr        = idx_inc;
          probe_idx_next = idx_inc;
          if (!stay) begin
            mem_we    = 1'b1;
            mem_waddr = hole;
            mem_wdata = rd;
            hole_next = probe_idx;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid || m_axis_tready) begin
          out_valid_next  = 1'b1;
          out_status_next = res_status;
          out_pool_next   = res_pool;
          out_pos_next    = res_pos;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      clr_idx   <= clr_idx_next;
      count     <= count_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    action     <= action_next;
    key        <= key_next;
    pool       <= pool_next;
    pos        <= pos_next;
    probe_idx  <= probe_idx_next;
    hole       <= hole_next;
    res_status <= res_status_next;
    res_pool   <= res_pool_next;
    res_pos    <= res_pos_next;
    out_status <= out_status_next;
    out_pool   <= out_pool_next;
    out_pos    <= out_pos_next;
  end

  a_load_bound: assert property (@(posedge clk) disable iff (rst)
    (2 * int'(count)) < (TABLE_SLOTS + 2))
    else $error("occupied count above half load");

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !mem_we)
    else $error("slot memory written while idle");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    ($rose(m_axis_tvalid) && !$past(rst)) |-> ($past(state) == ST_DONE))
    else $error("result shown without a finished request");

  a_shift_no_collide: assert property (@(posedge clk) disable iff (rst)
    (mem_we && state == ST_ERASE && state_next == ST_ERASE) |-> (mem_waddr != rd_addr))
    else $error("backward shift writes the slot it reads");

endmodule

// ----- dv/order_map_tracker_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// order_map_tracker_pkg
// Scoreboard for the hash map core. It keeps a private copy of the slot table,
// works out the response to every accepted request and checks the responses
// in arrival order.
// ----------------------------------------------------------------------------
package order_map_tracker_pkg;

  import lphm_pkg::*;

  localparam int MAP_SLOTS = 1024;
  localparam int POOL_W    = 4;
  localparam int POS_W     = 16;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [POOL_W-1:0]   pool;
    logic [POS_W-1:0]    slot;
  } map_response_t;

  class order_map_tracker;
    bit                live      [MAP_SLOTS];
    logic [KEY_W-1:0]  keys      [MAP_SLOTS];
    logic [POOL_W-1:0] pools     [MAP_SLOTS];
    logic [POS_W-1:0]  positions [MAP_SLOTS];
    int                fill;
    int                errors;
    map_response_t     awaited [$];

    function new();
      fill   = 0;
      errors = 0;
      foreach (live[i]) live[i] = 1'b0;
    endfunction

    function int home_slot(logic [KEY_W-1:0] key);
      return int'(key % MAP_SLOTS);
    endfunction

    function int next_slot(int i);
      return (i + 1 >= MAP_SLOTS) ? 0 : i + 1;
    endfunction

    function bit find_key(input logic [KEY_W-1:0] key, output int at, output int hole,
                          output bit has_hole);
      int i;
      int n;
      i        = home_slot(key);
      at       = 0;
      hole     = 0;
      has_hole = 1'b0;
      for (n = 0; n < MAP_SLOTS; n++) begin
        if (!live[i]) begin
          hole     = i;
          has_hole = 1'b1;
          return 1'b0;
        end
        if (keys[i] == key) begin
          at = i;
          return 1'b1;
        end
        i = next_slot(i);
      end
      return 1'b0;
    endfunction

    // backward-shift delete: pull later chain members into the hole
    function void shift_out(int hole);
      int j;
      int k;
      int n;
      bit stay;
      j = hole;
      for (n = 0; n < MAP_SLOTS; n++) begin
        j = next_slot(j);
        if (!live[j] || j == hole) break;
        k = home_slot(keys[j]);
        if (hole <= j) stay = (hole < k) && (k <= j);
        else stay = (hole < k) || (k <= j);
        if (!stay) begin
          keys[hole]      = keys[j];
          pools[hole]     = pools[j];
          positions[hole] = positions[j];
          hole            = j;
        end
      end
      live[hole] = 1'b0;
      if (fill > 0) fill--;
    endfunction

    function void note_request(logic [ACTION_W-1:0] act, logic [KEY_W-1:0] key,
                               logic [POOL_W-1:0] pool, logic [POS_W-1:0] slot);
      map_response_t rsp;
      int at;
      int hole;
      bit has_hole;
      rsp.status = STAT_ABSENT;
      rsp.pool   = '0;
      rsp.slot   = '0;
      case (act)
        ACT_INSERT: begin
          if (find_key(key, at, hole, has_hole)) begin
            pools[at]     = pool;
            positions[at] = slot;
            rsp.status    = STAT_OK;
          end else if (fill * 2 >= MAP_SLOTS || !has_hole) begin
            rsp.status = STAT_FULL;
          end else begin
            live[hole]      = 1'b1;
            keys[hole]      = key;
            pools[hole]     = pool;
            positions[hole] = slot;
            fill++;
            rsp.status = STAT_OK;
          end
        end
        ACT_LOOKUP: begin
          if (find_key(key, at, hole, has_hole)) begin
            rsp.status = STAT_OK;
            rsp.pool   = pools[at];
            rsp.slot   = positions[at];
          end
        end
        ACT_REMOVE: begin
          if (find_key(key, at, hole, has_hole)) begin
            shift_out(at);
            rsp.status = STAT_OK;
          end
        end
        default: ;
      endcase
      awaited.push_back(rsp);
    endfunction

    function void check_response(map_response_t got);
      map_response_t want;
      if (awaited.size() == 0) begin
        $display("%0t: response with none outstanding: status %0d pool %0d slot %0d",
                 $time, got.status, got.pool, got.slot);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.pool !== want.pool) begin
        $display("%0t: found_pool expected %0d actual %0d", $time, want.pool, got.pool);
        errors++;
      end
      if (got.slot !== want.slot) begin
        $display("%0t: found_slot expected %0d actual %0d", $time, want.slot, got.slot);
        errors++;
      end
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction
  endclass

endpackage

// ----- dv/tb_linear_probe_hash_map_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_map_core
// Drives insert, lookup and remove requests into the hash map core: a short
// directed run over chain wraparound, updates and backward-shift removal, then
// random traffic on clustered keys, a fill past the full mark and a drain.
// Both stream sides stall at random; responses are checked by the scoreboard.
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_map_core;

  import lphm_pkg::*;
  import order_map_tracker_pkg::*;

  localparam int S_W          = ((KEY_W + POOL_W + POS_W + 7) / 8) * 8;
  localparam int M_W          = ((POOL_W + POS_W + 7) / 8) * 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int STALL_LIMIT  = 6000;
  localparam int DRAIN_CYCLES = 64;

  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  typedef enum int {MIX_CLUSTERED, FILL_UP, DRAIN} traffic_mode_t;

  logic                clk           = 1'b0;
  logic                rst           = 1'b1;
  logic                s_axis_tvalid = 1'b0;
  logic [S_W-1:0]      s_axis_tdata  = '0;
  logic [ACTION_W-1:0] s_axis_tuser  = '0;
  logic                m_axis_tready = 1'b0;
  logic                s_axis_tready;
  logic                m_axis_tvalid;
  logic [M_W-1:0]      m_axis_tdata;
  logic [STATUS_W-1:0] m_axis_tuser;

  order_map_tracker   tracker;
  logic [KEY_W-1:0]   used_keys [$];
  bit                 steady        = 1'b0;
  int                 hold_requests = 0;
  int                 hold_served   = 0;
  int                 quiet_cycles  = 0;

  linear_probe_hash_map_core #(
    .TABLE_SLOTS  (MAP_SLOTS),
    .POOL_BITS    (POOL_W),
    .POSITION_BITS(POS_W)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #2 clk = ~clk;

  function automatic int idle_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [KEY_W-1:0] clustered_key();
    logic [KEY_W-1:0] key;
    key       = $urandom();
    key[9:0]  = 10'(($urandom_range(0, 15) + MAP_SLOTS - 8) % MAP_SLOTS);
    return key;
  endfunction

  function automatic logic [KEY_W-1:0] known_key();
    return used_keys[$urandom_range(0, used_keys.size() - 1)];
  endfunction

  task automatic send_request(input logic [ACTION_W-1:0] act, input logic [KEY_W-1:0] key,
                              input logic [POOL_W-1:0] pool, input logic [POS_W-1:0] slot);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(S_W - KEY_W - POOL_W - POS_W){1'b0}}, slot, pool, key};
    s_axis_tuser  <= act;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  task automatic run_directed();
    send_request(ACT_INSERT, 32'h0000_0000, 4'h0, 16'h0000);
    send_request(ACT_INSERT, 32'hFFFF_FFFF, 4'hF, 16'hFFFF);
    send_request(ACT_INSERT, 32'hABCD_E3FF, 4'h3, 16'h0101);
    send_request(ACT_INSERT, 32'h0000_0400, 4'h6, 16'h0202);
    send_request(ACT_LOOKUP, 32'hFFFF_FFFF, 4'h0, 16'h0000);
    send_request(ACT_LOOKUP, 32'hABCD_E3FF, 4'h0, 16'h0000);
    send_request(ACT_INSERT, 32'hABCD_E3FF, 4'h5, 16'h1234);
    send_request(ACT_LOOKUP, 32'hABCD_E3FF, 4'hF, 16'hFFFF);
    send_request(ACT_REMOVE, 32'hFFFF_FFFF, 4'h0, 16'h0000);
    send_request(ACT_LOOKUP, 32'hABCD_E3FF, 4'h0, 16'h0000);
    send_request(ACT_LOOKUP, 32'h0000_0400, 4'h0, 16'h0000);
    send_request(ACT_LOOKUP, 32'hFFFF_FFFF, 4'h0, 16'h0000);
    send_request(ACT_REMOVE, 32'hFFFF_FFFF, 4'h0, 16'h0000);
    send_request(ACT_UNUSED, 32'h0000_0000, 4'hF, 16'hFFFF);
    send_request(ACT_LOOKUP, 32'h0000_0000, 4'h0, 16'h0000);
    send_request(ACT_REMOVE, 32'h0000_0000, 4'h0, 16'h0000);
    send_request(ACT_LOOKUP, 32'h0000_0400, 4'h0, 16'h0000);
    send_request(ACT_INSERT, 32'h5555_5000, 4'hA, 16'h5555);
    send_request(ACT_INSERT, 32'hAAAA_A800, 4'h5, 16'hAAAA);
    send_request(ACT_LOOKUP, 32'h5555_5000, 4'h0, 16'h0000);
    send_request(ACT_REMOVE, 32'h0000_0400, 4'h0, 16'h0000);
    send_request(ACT_LOOKUP, 32'hAAAA_A800, 4'h0, 16'h0000);
    send_request(ACT_REMOVE, 32'hABCD_E3FF, 4'h0, 16'h0000);
    send_request(ACT_LOOKUP, 32'h0000_0400, 4'h0, 16'h0000);
    send_request(ACT_UNUSED, 32'hFFFF_FFFF, 4'h0, 16'h0000);
  endtask

  task automatic run_random(input traffic_mode_t mode, input int count);
    int                  n;
    int                  r;
    bit                  pick_known;
    logic [ACTION_W-1:0] act;
    logic [KEY_W-1:0]    key;
    for (n = 0; n < count; n++) begin
      if (n % 64 == 0) steady = ($urandom_range(0, 3) == 0);
      if (mode == MIX_CLUSTERED && n == count / 2) hold_requests++;
      r = $urandom_range(0, 99);
      case (mode)
        MIX_CLUSTERED: begin
          act        = (r < 40) ? ACT_INSERT : (r < 70) ? ACT_LOOKUP :
                       (r < 95) ? ACT_REMOVE : ACT_UNUSED;
          pick_known = ($urandom_range(0, 99) < 50);
        end
        FILL_UP: begin
          act        = (r < 85 || r >= 95) ? ACT_INSERT : ACT_LOOKUP;
          pick_known = (r >= 85);
        end
        default: begin
          act        = (r < 50 || r >= 97) ? ACT_REMOVE : (r < 85) ? ACT_LOOKUP : ACT_INSERT;
          pick_known = (r < 85);
        end
      endcase
      if (pick_known && used_keys.size() > 0) key = known_key();
      else if (mode == MIX_CLUSTERED) key = clustered_key();
      else key = $urandom();
      if (act == ACT_INSERT && !pick_known) used_keys.push_back(key);
      send_request(act, key, POOL_W'($urandom()), POS_W'($urandom()));
    end
  endtask

  // response side: random stalls, plus one long hold-off on request
  initial begin
    int gap;
    while (rst) @(posedge clk);
    forever begin
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = idle_gap();
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready)
        tracker.check_response({m_axis_tuser, m_axis_tdata[POOL_W-1:0],
                                m_axis_tdata[POOL_W+POS_W-1:POOL_W]});
      if (s_axis_tvalid && s_axis_tready)
        tracker.note_request(s_axis_tuser, s_axis_tdata[KEY_W-1:0],
                             s_axis_tdata[KEY_W+POOL_W-1:KEY_W],
                             s_axis_tdata[KEY_W+POOL_W+POS_W-1:KEY_W+POOL_W]);
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("tb_linear_probe_hash_map_core NOT OK");
        $finish;
      end
    end
  end

  initial begin
    tracker = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random(MIX_CLUSTERED, 300);
    run_random(FILL_UP, 620);
    run_random(DRAIN, 230);
    s_axis_tvalid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.outstanding() == 0)
      $display("tb_linear_probe_hash_map_core OK");
    else
      $display("tb_linear_probe_hash_map_core NOT OK");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/lphm_pkg.sv
design/lphm_home.sv
design/lphm_mem.sv
design/linear_probe_hash_map_core.sv
dv/order_map_tracker_pkg.sv
dv/tb_linear_probe_hash_map_core.sv
